/* src/sukl_pkg.sv */
// Shared types and constants of the sorted unique key list.
`default_nettype none
package sukl_pkg;

  localparam int KEY_W    = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int RANK_W   = 4;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LIST_ASC  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST_DESC = 3'd4;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;
  localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd7;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INS,
    OP_DEL,
    OP_ROTL,
    OP_ROTR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    key_t     key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* src/sukl_ifs.sv */
// Valid and ready channel interfaces for operation words and result words.
`default_nettype none
interface sukl_in_if;
  logic              valid;
  logic              ready;
  logic        [2:0] kind;
  logic signed [31:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface

interface sukl_out_if;
  logic              valid;
  logic              ready;
  logic        [2:0] status;
  logic signed [31:0] entry_key;
  logic        [3:0] rank;
  logic              last;

  modport source (output valid, output status, output entry_key, output rank, output last,
                  input ready);
  modport sink (input valid, input status, input entry_key, input rank, input last,
                output ready);
endinterface
`default_nettype wire

/* src/sukl_cell.sv */
// One key cell of the sorted chain: compares, shifts and rotates its stored key.
`default_nettype none
module sukl_cell (
  input  wire                  clk,
  input  wire sukl_pkg::cell_ctrl_t ctrl,
  input  wire                  valid,
  input  wire                  prev_lt,
  input  wire sukl_pkg::key_t  left_key,
  input  wire sukl_pkg::key_t  right_key,
  output sukl_pkg::key_t       key,
  output logic                 lt,
  output logic                 eq
);
  import sukl_pkg::*;

  key_t key_r;
  logic lt_r;
  logic eq_r;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_CMP: begin
        lt_r <= valid && (key_r < ctrl.key);
        eq_r <= valid && (key_r == ctrl.key);
      end
      OP_INS: begin
        if (!lt_r) begin
          key_r <= prev_lt ? ctrl.key : left_key;
        end
      end
      OP_DEL: begin
        if (!lt_r) begin
          key_r <= right_key;
        end
      end
      OP_ROTL: key_r <= right_key;
      OP_ROTR: key_r <= left_key;
      default: ;
    endcase
  end

  assign key = key_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule
`default_nettype wire

/* src/sorted_unique_key_list.sv */
// Sorted unique key list: top level with the cell chain and its sequencer.
// Insert, delete and search take the word, compare in every cell, then apply: shift the chain for
// an insert or a delete that succeeds, and register the result word.
// A listing takes the word, compares, decides, then makes one ring turn per cycle while no result
// word is held up. A result word waiting on back-pressure holds the sequencer, and with it the input.
// Synchronous active-low reset empties the list; the cell keys themselves are not cleared.
`default_nettype none
module sorted_unique_key_list #(
  parameter int CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  sukl_in_if.sink     in_ch,
  sukl_out_if.source  out_ch
);
  import sukl_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_LIST  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       step_r, step_nxt;
  logic [KIND_W-1:0]   kind_r;
  key_t                key_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  key_t                out_key_r, out_key_nxt;
  logic [RANK_W-1:0]   out_rank_r, out_rank_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;
  logic                out_free;

  cell_ctrl_t          ctrl;
  key_t                cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_valid;

  logic                any_eq;
  logic                desc;
  logic [IW-1:0]       pos;
  logic [IW+3:0]       pos_ext;
  logic                emit;
  logic                is_last;
  key_t                list_key;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign cell_valid[gi] = CW'(gi) < count_r;
      sukl_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (cell_valid[gi]),
        .prev_lt   ((gi == 0) ? 1'b1 : cell_lt[(gi + CAPACITY - 1) % CAPACITY]),
        .left_key  (cell_key[(gi + CAPACITY - 1) % CAPACITY]),
        .right_key (cell_key[(gi + 1) % CAPACITY]),
        .key       (cell_key[gi]),
        .lt        (cell_lt[gi]),
        .eq        (cell_eq[gi])
      );
    end
  endgenerate

  assign any_eq   = |cell_eq;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // The ring turns once per listing: ascending reads the lowest cell before each left turn,
  // descending reads the highest cell before each right turn.
  assign desc     = (kind_r == KIND_LIST_DESC);
  assign pos      = desc ? (IW'(CAPACITY - 1) - step_r) : step_r;
  assign pos_ext  = {4'b0000, pos};
  assign emit     = {{(CW - IW){1'b0}}, pos} < count_r;
  assign is_last  = desc ? (step_r == IW'(CAPACITY - 1))
                         : ({{(CW - IW){1'b0}}, pos} == count_r - CW'(1));
  assign list_key = desc ? cell_key[CAPACITY-1] : cell_key[0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    ctrl.op        = OP_HOLD;
    ctrl.key       = key_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_key_nxt    = key_r;
    out_rank_nxt   = '0;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.kind) inside
            KIND_INSERT, KIND_DELETE, KIND_SEARCH, KIND_LIST_ASC, KIND_LIST_DESC:
              state_nxt = S_CMP;
            default: ;
          endcase
        end
      end
      S_CMP: begin
        ctrl.op   = OP_CMP;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          out_load  = 1'b1;
          case (kind_r)
            KIND_INSERT: begin
              if (any_eq) begin
                out_status_nxt = ST_DUPLICATE;
              end else if (count_r == CW'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_INSERTED;
                ctrl.op        = OP_INS;
                count_nxt      = count_r + CW'(1);
              end
            end
            KIND_DELETE, KIND_SEARCH: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (!any_eq) begin
                out_status_nxt = ST_NOT_FOUND;
              end else if (kind_r == KIND_SEARCH) begin
                out_status_nxt = ST_FOUND;
              end else begin
                out_status_nxt = ST_DELETED;
                ctrl.op        = OP_DEL;
                count_nxt      = count_r - CW'(1);
              end
            end
            default: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
                out_key_nxt    = '0;
              end else begin
                out_load  = 1'b0;
                step_nxt  = '0;
                state_nxt = S_LIST;
              end
            end
          endcase
        end
      end
      S_LIST: begin
        if (!emit || out_free) begin
          ctrl.op        = desc ? OP_ROTR : OP_ROTL;
          out_load       = emit;
          out_status_nxt = ST_LISTED;
          out_key_nxt    = list_key;
          out_rank_nxt   = pos_ext[3:0];
          out_last_nxt   = is_last;
          if (step_r == IW'(CAPACITY - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + IW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      key_r  <= in_ch.key;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_key_r    <= out_key_nxt;
      out_rank_r   <= out_rank_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.entry_key = out_key_r;
  assign out_ch.rank      = out_rank_r;
  assign out_ch.last      = out_last_r;

endmodule
`default_nettype wire

/* tb/sv/key_list_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts and compares the result words of the sorted unique key list.
module key_list_checker #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sukl_in_if         in_mon,
  sukl_out_if        out_mon,
  output int         fail_count,
  output int         pending_results
);
  import sukl_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    key_t                entry_key;
    logic [RANK_W-1:0]   rank;
    logic                last;
  } result_word_t;

  key_t         stored_keys [CAPACITY];
  int           stored_count = 0;
  result_word_t awaited_results [$];
  int           mismatches = 0;
  result_word_t got;
  result_word_t want;

  function automatic void await_result(input logic [STATUS_W-1:0] status, input key_t entry_key,
                                       input logic [RANK_W-1:0] rank, input logic last);
    result_word_t word;
    word.status    = status;
    word.entry_key = entry_key;
    word.rank      = rank;
    word.last      = last;
    awaited_results.push_back(word);
  endfunction

  function automatic void apply_operation(input logic [KIND_W-1:0] kind, input key_t key);
    int pos;
    int idx;
    int rank_pos;
    pos = 0;
    while (pos < stored_count && stored_keys[pos] < key) pos++;
    case (kind)
      KIND_INSERT: begin
        if (pos < stored_count && stored_keys[pos] == key) begin
          await_result(ST_DUPLICATE, key, '0, 1'b1);
        end else if (stored_count >= CAPACITY) begin
          await_result(ST_FULL, key, '0, 1'b1);
        end else begin
          for (idx = stored_count; idx > pos; idx--) stored_keys[idx] = stored_keys[idx - 1];
          stored_keys[pos] = key;
          stored_count++;
          await_result(ST_INSERTED, key, '0, 1'b1);
        end
      end
      KIND_DELETE, KIND_SEARCH: begin
        if (stored_count == 0) begin
          await_result(ST_EMPTY, key, '0, 1'b1);
        end else if (pos >= stored_count || stored_keys[pos] != key) begin
          await_result(ST_NOT_FOUND, key, '0, 1'b1);
        end else if (kind == KIND_SEARCH) begin
          await_result(ST_FOUND, key, '0, 1'b1);
        end else begin
          for (idx = pos; idx + 1 < stored_count; idx++) stored_keys[idx] = stored_keys[idx + 1];
          stored_count--;
          await_result(ST_DELETED, key, '0, 1'b1);
        end
      end
      KIND_LIST_ASC, KIND_LIST_DESC: begin
        if (stored_count == 0) begin
          await_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (idx = 0; idx < stored_count; idx++) begin
            rank_pos = (kind == KIND_LIST_ASC) ? idx : stored_count - 1 - idx;
            await_result(ST_LISTED, stored_keys[rank_pos], rank_pos[RANK_W-1:0],
                         idx == stored_count - 1);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input result_word_t exp_word,
                                        input result_word_t act_word);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d (status/key/rank/last)",
               $time, what, exp_word.status, exp_word.entry_key, exp_word.rank, exp_word.last,
               act_word.status, act_word.entry_key, act_word.rank, act_word.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      stored_count = 0;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status    = out_mon.status;
        got.entry_key = out_mon.entry_key;
        got.rank      = out_mon.rank;
        got.last      = out_mon.last;
        if (awaited_results.size() == 0) begin
          note_mismatch("word with none awaited", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.entry_key !== want.entry_key ||
              got.rank !== want.rank || got.last !== want.last) begin
            note_mismatch("wrong result word", want, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_operation(in_mon.kind, in_mon.key);
      end
    end
    fail_count      <= mismatches;
    pending_results <= awaited_results.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, operation stimulus, result back-pressure and verdict.
module testbench;
  import sukl_pkg::*;

  localparam int   CAPACITY          = 16;
  localparam int   WORDS_PER_PHASE   = 100;
  localparam int   MOOD_SPAN         = 40;
  localparam int   POOL_SIZE         = 24;
  localparam int   FIXED_POOL        = 5;
  localparam key_t KEY_MIN           = 32'sh8000_0000;
  localparam key_t KEY_MAX           = 32'sh7fff_ffff;
  localparam int   RUN_LIMIT_NS      = 4_000_000;

  typedef enum int {
    MOOD_FILL,
    MOOD_DRAIN,
    MOOD_MIXED
  } mood_t;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   stall_pct;
  int   fail_count;
  int   pending_results;
  key_t key_pool [POOL_SIZE];

  sukl_in_if  in_ch ();
  sukl_out_if out_ch ();

  sorted_unique_key_list #(
    .CAPACITY (CAPACITY)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_list_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input key_t key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.key   <= key;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic key_t pick_key();
    key_t fresh;
    fresh = $urandom;
    if ($urandom_range(99) < 15) begin
      key_pool[$urandom_range(POOL_SIZE - 1, FIXED_POOL)] = fresh;
      return fresh;
    end
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input mood_t mood);
    int roll;
    int insert_pct;
    case (mood)
      MOOD_FILL:  insert_pct = 85;
      MOOD_DRAIN: insert_pct = 25;
      default:    insert_pct = 55;
    endcase
    roll = $urandom_range(99);
    if (roll < 3) return KIND_LIST_DESC + KIND_W'(1 + $urandom_range(2));
    if (roll < 9) return KIND_LIST_ASC;
    if (roll < 15) return KIND_LIST_DESC;
    if (roll < 27) return KIND_SEARCH;
    return ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
  endfunction

  initial begin
    int                phase;
    int                counted;
    mood_t             mood;
    logic [KIND_W-1:0] kind;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_INSERT;
    in_ch.key     <= '0;
    rst_n         <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    key_pool[0]   = KEY_MIN;
    key_pool[1]   = KEY_MAX;
    key_pool[2]   = 0;
    key_pool[3]   = -1;
    key_pool[4]   = 1;
    for (int i = FIXED_POOL; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_word(KIND_LIST_ASC, KEY_MAX);
    send_word(KIND_LIST_DESC, KEY_MIN);
    send_word(KIND_DELETE, 7);
    send_word(KIND_SEARCH, KEY_MIN);
    send_word(KIND_INSERT, KEY_MAX);
    send_word(KIND_INSERT, KEY_MIN);
    send_word(KIND_INSERT, 0);
    send_word(KIND_INSERT, -1);
    send_word(KIND_INSERT, 1);
    send_word(KIND_INSERT, KEY_MIN);
    send_word(KIND_SEARCH, -1);
    send_word(KIND_SEARCH, 2);
    send_word(KIND_DELETE, 2);
    send_word(KIND_LIST_ASC, 0);
    send_word(KIND_DELETE, KEY_MAX);
    send_word(KIND_DELETE, KEY_MIN);
    send_word(KIND_LIST_DESC, -1);
    send_word(KIND_LIST_DESC + KIND_W'(1), KEY_MAX);
    send_word(KIND_LIST_DESC + KIND_W'(2), KEY_MIN);
    send_word(KIND_LIST_DESC + KIND_W'(3), -1);
    send_word(KIND_SEARCH, 1);
    send_word(KIND_LIST_ASC, KEY_MIN);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 67;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 67;
        end
        default: begin
          send_idle_pct = 27;
          stall_pct     = 27;
        end
      endcase
      counted = 0;
      mood    = MOOD_FILL;
      while (counted < WORDS_PER_PHASE) begin
        if (counted > 0 && counted % MOOD_SPAN == 0) mood = mood_t'($urandom_range(2));
        kind = pick_kind(mood);
        send_word(kind, pick_key());
        if (kind <= KIND_LIST_DESC) counted++;
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/sukl_pkg.sv
src/sukl_ifs.sv
src/sukl_cell.sv
src/sorted_unique_key_list.sv
tb/sv/key_list_checker.sv
tb/sv/testbench.sv
